// ===== sv/tlge_pkg.sv =====
`timescale 1ns / 1ps

package tlge_pkg;

    // Fixed field widths of the item and configuration ports, and of the neighbor count.
    localparam int ACT_W  = 2;
    localparam int IDX_W  = 6;
    localparam int CELL_W = 64;
    localparam int CFG_W  = 7;
    localparam int CNT_W  = 4;

    // Item kinds carried on the action field.
    localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_STEP  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_NONE  = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] ROWS_RESET = 7'd64;
    localparam logic [CFG_W-1:0] COLS_RESET = 7'd64;

    // Neighborhood counts (cell included) that give a live cell.
    localparam logic [CNT_W-1:0] CNT_BIRTH   = 4'd3;
    localparam logic [CNT_W-1:0] CNT_SURVIVE = 4'd4;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_STEP,
        S_DRAIN
    } t_state;

endpackage

// ===== sv/tlge_ram.sv =====
`timescale 1ns / 1ps

module tlge_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/toroidal_life_generation_engine_core.sv =====
`timescale 1ns / 1ps

// Wrap-around Life grid engine (birth on 3, survival on 2 or 3 neighbors).
// Items come in on start/busy: an item is taken at a clock edge with start
// high and busy low. Action write loads one row, read returns one row, step
// advances the whole grid one generation. Every item yields one result beat:
// o_done_strobe is high for exactly one cycle with o_done_kind and
// o_read_cells, and the receiver cannot hold it off.
// Write, read and the unused action leave busy low; their beat comes in the
// next cycle, so one such item can follow per cycle.
// A step streams the source bank through the single read port of its memory:
// MAX_ROWS + 2 reads (the in-use rows plus the two wrap rows, then the rows
// out of use, which are copied), then a drain state. busy is high through
// the step and drain states, and the beat comes right after.
// The grid lives in two banks; a step writes the idle bank and flips banks.
// After reset a clearing pass zeroes every row of both banks while
// busy is high; configuration writes are taken at any time and should be
// made only while the block is idle.
module toroidal_life_generation_engine_core
    import tlge_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [ACT_W-1:0]  i_action,
    input  logic [IDX_W-1:0]  i_row_index,
    input  logic [CELL_W-1:0] i_row_cells,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    output logic              o_done_strobe,
    output logic [CELL_W-1:0] o_read_cells,
    output logic [ACT_W-1:0]  o_done_kind
);

    localparam int AW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int KW   = $clog2(MAX_ROWS + 3);
    localparam int CMPW = (KW > CFG_W) ? KW : CFG_W;
    localparam int IXW  = AW + IDX_W;
    localparam int CIW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int LAST = MAX_ROWS + 1;

    t_state r_state, n_state;

    logic [CFG_W-1:0]    r_rows;
    logic [CFG_W-1:0]    r_cols;
    logic                r_live;
    logic [KW-1:0]       r_k, n_k;
    logic                r_rv;
    logic [KW-1:0]       r_rk;
    logic [MAX_COLS-1:0] r_w0;
    logic [MAX_COLS-1:0] r_w1;
    logic                r_out_valid;
    logic [ACT_W-1:0]    r_out_kind;
    logic                r_out_is_read;
    logic                r_rd_hit;
    logic                r_rd_bank;

    logic                w_accept;
    logic                w_issue;
    logic                w_drain;
    logic [IXW-1:0]      w_idx_wide;
    logic [AW-1:0]       w_addr;
    logic                w_in_range;
    logic [KW-1:0]       w_eff_rows;
    logic [CFG_W-1:0]    w_eff_cols;
    logic [MAX_COLS-1:0] w_mask;
    logic [KW-1:0]       w_seq;
    logic [KW-1:0]       w_dst_row;
    logic [MAX_COLS-1:0] w_src_raw;
    logic [MAX_COLS-1:0] w_src_masked;
    logic [MAX_COLS-1:0] w_life;
    logic [MAX_COLS-1:0] w_rd_raw;

    logic                w_we    [2];
    logic [AW-1:0]       w_waddr [2];
    logic [MAX_COLS-1:0] w_wdata [2];
    logic                w_re    [2];
    logic [AW-1:0]       w_raddr [2];
    logic [MAX_COLS-1:0] w_rdata [2];

    // Left neighbor of every column, wrapping at the last column in use.
    function automatic logic [MAX_COLS-1:0] f_left(input logic [MAX_COLS-1:0] x,
                                                   input logic [CIW-1:0] top);
        logic [2*MAX_COLS-1:0] xx;
        logic [MAX_COLS-1:0]   y;
        xx = {x, x};
        for (int j = 0; j < MAX_COLS; j++) begin
            y[j] = (j == 0) ? x[top] : xx[j + MAX_COLS - 1];
        end
        return y;
    endfunction

    // Right neighbor of every column, wrapping back to column zero.
    function automatic logic [MAX_COLS-1:0] f_right(input logic [MAX_COLS-1:0] x,
                                                    input logic [CFG_W-1:0] c);
        logic [2*MAX_COLS-1:0] xx;
        logic [MAX_COLS-1:0]   y;
        xx = {x, x};
        for (int j = 0; j < MAX_COLS; j++) begin
            y[j] = (CFG_W'(j + 1) >= c) ? x[0] : xx[j + 1];
        end
        return y;
    endfunction

    // Handshake and address decode of the incoming item.
    assign w_accept   = start && !busy;
    assign w_idx_wide = IXW'(i_row_index);
    assign w_addr     = w_idx_wide[AW-1:0];
    assign w_in_range = w_idx_wide < IXW'(MAX_ROWS);

    // Rows and columns in use, saturated into their legal ranges.
    always_comb begin
        if (r_rows == '0) begin
            w_eff_rows = KW'(1);
        end else if (CMPW'(r_rows) > CMPW'(MAX_ROWS)) begin
            w_eff_rows = KW'(MAX_ROWS);
        end else begin
            w_eff_rows = KW'(r_rows);
        end
        if (r_cols == '0) begin
            w_eff_cols = CFG_W'(1);
        end else if (r_cols > CFG_W'(MAX_COLS)) begin
            w_eff_cols = CFG_W'(MAX_COLS);
        end else begin
            w_eff_cols = r_cols;
        end
        for (int j = 0; j < MAX_COLS; j++) begin
            w_mask[j] = CFG_W'(j) < w_eff_cols;
        end
    end

    // Read order of a step: wrap row, in-use rows, row zero, then unused rows.
    always_comb begin
        if (r_k == '0) begin
            w_seq = w_eff_rows - KW'(1);
        end else if (r_k <= w_eff_rows) begin
            w_seq = r_k - KW'(1);
        end else if (r_k == w_eff_rows + KW'(1)) begin
            w_seq = '0;
        end else begin
            w_seq = r_k - KW'(2);
        end
    end

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_k == KW'(MAX_ROWS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept && i_action == ACT_STEP) begin
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                if (r_k == KW'(LAST)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Sequencer outputs: busy, read issue, drain and the row counter.
    always_comb begin
        busy    = 1'b1;
        w_issue = 1'b0;
        w_drain = 1'b0;
        n_k     = '0;
        case (r_state)
            S_CLEAR: begin
                n_k = r_k + KW'(1);
            end
            S_IDLE: begin
                busy = 1'b0;
            end
            S_STEP: begin
                w_issue = 1'b1;
                n_k     = r_k + KW'(1);
            end
            S_DRAIN: begin
                w_drain = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    // Source row from the live bank and the next generation of the middle row.
    assign w_src_raw    = w_rdata[r_live];
    assign w_src_masked = w_src_raw & w_mask;
    assign w_dst_row    = r_rk - KW'(2);

    always_comb begin
        logic [CIW-1:0]      v_top;
        logic [MAX_COLS-1:0] v_ul, v_ur, v_ml, v_mr, v_dl, v_dr;
        logic [CNT_W-1:0]    v_cnt;
        v_top = CIW'(w_eff_cols - CFG_W'(1));
        v_ul  = f_left(r_w0, v_top);
        v_ur  = f_right(r_w0, w_eff_cols);
        v_ml  = f_left(r_w1, v_top);
        v_mr  = f_right(r_w1, w_eff_cols);
        v_dl  = f_left(w_src_masked, v_top);
        v_dr  = f_right(w_src_masked, w_eff_cols);
        for (int j = 0; j < MAX_COLS; j++) begin
            v_cnt = CNT_W'(v_ul[j]) + CNT_W'(r_w0[j]) + CNT_W'(v_ur[j])
                  + CNT_W'(v_ml[j]) + CNT_W'(r_w1[j]) + CNT_W'(v_mr[j])
                  + CNT_W'(v_dl[j]) + CNT_W'(w_src_masked[j]) + CNT_W'(v_dr[j]);
            w_life[j] = w_mask[j] &
                        ((v_cnt == CNT_BIRTH) || (v_cnt == CNT_SURVIVE && r_w1[j]));
        end
    end

    // Memory port control for both banks.
    always_comb begin
        for (int b = 0; b < 2; b++) begin
            w_we[b]    = 1'b0;
            w_waddr[b] = '0;
            w_wdata[b] = '0;
            w_re[b]    = 1'b0;
            w_raddr[b] = '0;
            case (r_state)
                S_CLEAR: begin
                    w_we[b]    = 1'b1;
                    w_waddr[b] = r_k[AW-1:0];
                end
                S_IDLE: begin
                    if (w_accept && w_in_range && 1'(b) == r_live) begin
                        if (i_action == ACT_WRITE) begin
                            w_we[b]    = 1'b1;
                            w_waddr[b] = w_addr;
                            w_wdata[b] = i_row_cells[MAX_COLS-1:0] & w_mask;
                        end
                        if (i_action == ACT_READ) begin
                            w_re[b]    = 1'b1;
                            w_raddr[b] = w_addr;
                        end
                    end
                end
                S_STEP: begin
                    if (1'(b) == r_live) begin
                        w_re[b]    = 1'b1;
                        w_raddr[b] = w_seq[AW-1:0];
                    end
                end
                default: begin
                    w_re[b] = 1'b0;
                end
            endcase
            // New rows go to the idle bank; rows out of use are copied as stored.
            if (r_rv && 1'(b) != r_live && r_rk >= KW'(2)) begin
                w_we[b]    = 1'b1;
                w_waddr[b] = w_dst_row[AW-1:0];
                w_wdata[b] = (w_dst_row < w_eff_rows) ? w_life : w_src_raw;
            end
        end
    end

    for (genvar g = 0; g < 2; g++) begin : g_bank
        tlge_ram #(
            .WIDTH (MAX_COLS),
            .DEPTH (MAX_ROWS)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_we[g]),
            .i_waddr (w_waddr[g]),
            .i_wdata (w_wdata[g]),
            .i_re    (w_re[g]),
            .i_raddr (w_raddr[g]),
            .o_rdata (w_rdata[g])
        );
    end

    // Control state: sequencer, configuration, bank select and result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_k         <= '0;
            r_rows      <= ROWS_RESET;
            r_cols      <= COLS_RESET;
            r_live      <= 1'b0;
            r_rv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_rv        <= w_issue;
            r_out_valid <= (w_accept && i_action != ACT_STEP) || w_drain;
            if (w_drain) begin
                r_live <= ~r_live;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ROWS: r_rows <= i_cfg_data;
                    CFG_COLS: r_cols <= i_cfg_data;
                    default: begin
                        r_rows <= r_rows;
                    end
                endcase
            end
        end
    end

    // Row window of a step and the payload of the next result beat.
    always_ff @(posedge i_clk) begin
        r_rk <= r_k;
        if (r_rv) begin
            r_w0 <= r_w1;
            r_w1 <= w_src_masked;
        end
        if (w_accept) begin
            r_out_kind    <= i_action;
            r_out_is_read <= i_action == ACT_READ;
            r_rd_hit      <= w_in_range;
            r_rd_bank     <= r_live;
        end else if (w_drain) begin
            r_out_kind    <= ACT_STEP;
            r_out_is_read <= 1'b0;
        end
    end

    // Result beat; read data comes straight from the registered memory output.
    assign w_rd_raw      = w_rdata[r_rd_bank] & w_mask;
    assign o_done_strobe = r_out_valid;
    assign o_done_kind   = r_out_kind;
    assign o_read_cells  = (r_out_is_read && r_rd_hit) ? CELL_W'(w_rd_raw) : '0;

endmodule
